// ===== hw/rtl/lcrs_pkg.sv =====
// Shared types and constants of the line-scan camera readout sequencer.
package lcrs_pkg;

  // Default sizes of the pixel store.
  localparam int unsigned PixelsDef     = 128;
  localparam int unsigned SampleBitsDef = 12;

  // Fixed widths of the word fields.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned AdcW   = 12;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned LevelW = 12;

  typedef enum logic [FuncW-1:0] {
    FN_START = 2'd0,
    FN_DONE  = 2'd1,
    FN_READ  = 2'd2,
    FN_APPLY = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SCAN = 3'd1,
    PH_POT0 = 3'd2,
    PH_POT1 = 3'd3,
    PH_BATT = 3'd4
  } phase_e;

  typedef enum logic [ChanW-1:0] {
    CH_NONE = 3'd0,
    CH_CAM  = 3'd1,
    CH_POT0 = 3'd2,
    CH_POT1 = 3'd3,
    CH_BATT = 3'd4
  } chan_e;

  // Result word without the pixel, which arrives later from the store's registered read.
  typedef struct packed {
    chan_e             next_channel;
    logic              si_pulse;
    logic              clock_pulse;
    logic              buffers_swapped;
    logic              swap_deferred;
    logic [LevelW-1:0] pot0_level;
    logic [LevelW-1:0] pot1_level;
    logic [LevelW-1:0] battery_level;
    logic              battery_updated;
  } ctl_res_t;

endpackage

// ===== hw/rtl/lcrs_if.sv =====
// Valid/ready channel interfaces for the request and result words.
interface lcrs_in_if;
  import lcrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [AdcW-1:0]   adc_value;
  logic              calc_busy;
  logic [IdxW-1:0]   pixel_index;

  modport source (output valid, func, adc_value, calc_busy, pixel_index, input ready);
  modport sink   (input valid, func, adc_value, calc_busy, pixel_index, output ready);
endinterface

interface lcrs_out_if;
  import lcrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  next_channel;
  logic              si_pulse;
  logic              clock_pulse;
  logic              buffers_swapped;
  logic              swap_deferred;
  logic [LevelW-1:0] pixel_data;
  logic [LevelW-1:0] pot0_level;
  logic [LevelW-1:0] pot1_level;
  logic [LevelW-1:0] battery_level;
  logic              battery_updated;

  modport source (
    output valid, next_channel, si_pulse, clock_pulse, buffers_swapped, swap_deferred,
           pixel_data, pot0_level, pot1_level, battery_level, battery_updated,
    input  ready
  );
  modport sink (
    input  valid, next_channel, si_pulse, clock_pulse, buffers_swapped, swap_deferred,
           pixel_data, pot0_level, pot1_level, battery_level, battery_updated,
    output ready
  );
endinterface

// ===== hw/rtl/lcrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lcrs_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/linescan_camera_readout_sequencer.sv =====
// Top level of the line-scan camera readout sequencer with ping-pong pixel store.
// Pipeline: a word passes stage one (which covers the store's registered read) and then the
//   result register before its result is offered.
// Throughput: one word per cycle while the sink takes results; the store has one write and
//   one read port, and each word uses at most one of them.
// Reset: rst_ni clears the phase, pixel count, halves, pending swap and levels at once;
//   the pixel store is not cleared, so a half reads as garbage until it is filled.
module linescan_camera_readout_sequencer #(
  parameter int unsigned PIXELS      = lcrs_pkg::PixelsDef,
  parameter int unsigned SAMPLE_BITS = lcrs_pkg::SampleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcrs_in_if.sink     in_i,
  lcrs_out_if.source  out_o
);

  import lcrs_pkg::*;

  // Store holds two halves of PIXELS samples each; the count runs up to PIXELS.
  localparam int unsigned Depth = 2 * PIXELS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(PIXELS + 1);
  localparam logic [CW-1:0] PixCount = CW'(PIXELS);
  localparam logic [AW-1:0] HalfBase = AW'(PIXELS);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  phase_e            phase_q, phase_d;
  logic [CW-1:0]     count_q, count_d;
  logic              write_half_q, write_half_d;
  logic              pending_q, pending_d;
  logic [LevelW-1:0] pot0_q, pot0_d;
  logic [LevelW-1:0] pot1_q, pot1_d;
  logic [LevelW-1:0] batt_q, batt_d;

  // Stage one: result word waiting for the store's read data.
  logic     s1_valid_q, s1_valid_d;
  ctl_res_t s1_q;
  logic     s1_rd_q;
  logic     s1_adv;

  // Output register.
  logic              out_valid_q;
  ctl_res_t          out_q;
  logic [LevelW-1:0] out_pix_q;

  // Store port signals.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   idx_ok;
  ctl_res_t               res;

  // Stage one advances whenever the output register is free or drains this cycle;
  // a new word enters whenever stage one is empty or advances.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // Keep only the converter bits the store is sized for.
  assign sample = SAMPLE_BITS'(in_i.adc_value);
  assign idx_ok = 32'(in_i.pixel_index) < PIXELS;

  // ---------------------------------------------------------------------------
  // Sequencer: next state and the control part of the result word.
  // The store write goes to the write half, reads to the other half. A read of a
  // half can only follow its last write by two or more words (the extra-sample
  // word sits between them), and the write lands before any later read is
  // issued, so no forwarding path is needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d      = phase_q;
    count_d      = count_q;
    write_half_d = write_half_q;
    pending_d    = pending_q;
    pot0_d       = pot0_q;
    pot1_d       = pot1_q;
    batt_d       = batt_q;
    ram_we       = 1'b0;
    ram_waddr    = write_half_q ? HalfBase + AW'(count_q) : AW'(count_q);
    ram_wdata    = sample;
    ram_re       = 1'b0;
    ram_raddr    = write_half_q ? AW'(in_i.pixel_index) : HalfBase + AW'(in_i.pixel_index);
    res          = '0;
    res.next_channel = CH_NONE;

    if (in_acc) begin
      unique case (func_e'(in_i.func))
        FN_START: begin
          // Restart the line from pixel zero; keep any pending swap.
          res.si_pulse     = 1'b1;
          res.clock_pulse  = 1'b1;
          res.next_channel = CH_CAM;
          count_d          = '0;
          phase_d          = PH_SCAN;
        end
        FN_DONE: begin
          unique case (phase_q)
            PH_SCAN: begin
              res.clock_pulse = 1'b1;
              if (count_q < PixCount) begin
                ram_we           = 1'b1;
                count_d          = count_q + 1'b1;
                res.next_channel = CH_CAM;
              end else begin
                // Drop the extra sample, then swap or defer while processing is busy.
                phase_d          = PH_POT0;
                res.next_channel = CH_POT0;
                if (!in_i.calc_busy) begin
                  write_half_d        = !write_half_q;
                  res.buffers_swapped = 1'b1;
                end else begin
                  pending_d = 1'b1;
                end
              end
            end
            PH_POT0: begin
              pot0_d           = LevelW'(sample);
              phase_d          = PH_POT1;
              res.next_channel = CH_POT1;
            end
            PH_POT1: begin
              pot1_d           = LevelW'(sample);
              phase_d          = PH_BATT;
              res.next_channel = CH_BATT;
            end
            PH_BATT: begin
              batt_d              = LevelW'(sample);
              res.battery_updated = 1'b1;
              phase_d             = PH_IDLE;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        FN_READ: begin
          ram_re = idx_ok;
        end
        FN_APPLY: begin
          if (pending_q) begin
            write_half_d        = !write_half_q;
            pending_d           = 1'b0;
            res.buffers_swapped = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res.swap_deferred = pending_d;
    res.pot0_level    = pot0_d;
    res.pot1_level    = pot1_d;
    res.battery_level = batt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      write_half_q <= 1'b0;
      pending_q    <= 1'b0;
      pot0_q       <= '0;
      pot1_q       <= '0;
      batt_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      write_half_q <= write_half_d;
      pending_q    <= pending_d;
      pot0_q       <= pot0_d;
      pot1_q       <= pot1_d;
      batt_q       <= batt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel store
  // ---------------------------------------------------------------------------
  lcrs_ram #(
    .Width (SAMPLE_BITS),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage one and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q    <= res;
      s1_rd_q <= ram_re;
    end
    if (s1_adv) begin
      out_q     <= s1_q;
      out_pix_q <= s1_rd_q ? LevelW'(ram_rdata) : '0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.next_channel    = out_q.next_channel;
  assign out_o.si_pulse        = out_q.si_pulse;
  assign out_o.clock_pulse     = out_q.clock_pulse;
  assign out_o.buffers_swapped = out_q.buffers_swapped;
  assign out_o.swap_deferred   = out_q.swap_deferred;
  assign out_o.pixel_data      = out_pix_q;
  assign out_o.pot0_level      = out_q.pot0_level;
  assign out_o.pot1_level      = out_q.pot1_level;
  assign out_o.battery_level   = out_q.battery_level;
  assign out_o.battery_updated = out_q.battery_updated;

`ifndef NO_ASSERTIONS
  // Store read data must hold while its word waits in stage one.
  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(ram_rdata))
    else $error("store read data changed under a stalled word");

  // Writes stay in the write half.
  a_write_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((ram_waddr >= HalfBase) == write_half_q))
    else $error("pixel write outside the write half");

  // Reads stay in the read half.
  a_read_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> ((ram_raddr >= HalfBase) != write_half_q))
    else $error("pixel read outside the read half");

  // A swap becomes pending only on the extra-sample word while processing is busy.
  a_pending_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(in_acc && in_i.func == FN_DONE && phase_q == PH_SCAN
                               && in_i.calc_busy))
    else $error("swap deferred without a busy end of line");

  // Stage one never accepts a word over an unread one.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_valid_q || s1_adv))
    else $error("stage one overwritten");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the line-scan camera readout sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcrs_pkg::*;

  localparam int unsigned PIXELS       = PixelsDef;
  localparam int unsigned SMP_MASK     = (1 << SampleBitsDef) - 1;
  localparam int unsigned HOLD_CYCLES  = 300;      // long sink hold-off for backpressure
  localparam int unsigned DRAIN_CYCLES = 20;       // idle time to watch for stray results
  localparam int unsigned CYCLE_LIMIT  = 200_000;  // well above the slowest legal run
  localparam int unsigned MAX_REPORTS  = 10;

  // One result word as the block should present it.
  typedef struct packed {
    chan_e             next_channel;
    logic              si_pulse;
    logic              clock_pulse;
    logic              buffers_swapped;
    logic              swap_deferred;
    logic [LevelW-1:0] pixel_data;
    logic [LevelW-1:0] pot0_level;
    logic [LevelW-1:0] pot1_level;
    logic [LevelW-1:0] battery_level;
    logic              battery_updated;
  } readout_t;

  logic clk_i;
  logic rst_ni;

  lcrs_in_if  in_bus ();
  lcrs_out_if out_bus ();

  linescan_camera_readout_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Sequencer state as the testbench tracks it; updated once per accepted word.
  phase_e            scan_phase;
  int unsigned       px_cnt;
  bit                wr_half;        // half being filled; the other half is read
  bit                swap_pending;
  logic [LevelW-1:0] pot0_lvl;
  logic [LevelW-1:0] pot1_lvl;
  logic [LevelW-1:0] batt_lvl;
  logic [LevelW-1:0] line_mem  [2*PIXELS];
  bit                line_seen [2*PIXELS];  // entries written since reset

  readout_t    readout_q[$];   // results still owed by the block, oldest first
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Idling knobs, reshuffled during the run so both busy and quiet stretches occur.
  bit src_idle;
  bit snk_idle;
  bit hold_req;                // ask the sink for one long hold-off

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the result of one word and advance the tracked state.
  function automatic readout_t predict_word(func_e f, logic [AdcW-1:0] adc, logic busy,
                                            logic [IdxW-1:0] idx);
    readout_t          r;
    logic [LevelW-1:0] smp;
    r   = '0;
    smp = LevelW'(adc & SMP_MASK);
    case (f)
      FN_START: begin
        // Restart from pixel 0 in any phase; a pending swap survives.
        r.si_pulse     = 1'b1;
        r.clock_pulse  = 1'b1;
        r.next_channel = CH_CAM;
        px_cnt         = 0;
        scan_phase     = PH_SCAN;
      end
      FN_DONE: begin
        case (scan_phase)
          PH_SCAN: begin
            r.clock_pulse = 1'b1;
            if (px_cnt < PIXELS) begin
              line_mem[int'(wr_half) * PIXELS + px_cnt]  = smp;
              line_seen[int'(wr_half) * PIXELS + px_cnt] = 1'b1;
              px_cnt++;
              r.next_channel = CH_CAM;
            end else begin
              // Trailing sample is dropped; swap now or defer while busy.
              scan_phase     = PH_POT0;
              r.next_channel = CH_POT0;
              if (!busy) begin
                wr_half           = ~wr_half;
                r.buffers_swapped = 1'b1;
              end else begin
                swap_pending = 1'b1;
              end
            end
          end
          PH_POT0: begin
            pot0_lvl       = smp;
            scan_phase     = PH_POT1;
            r.next_channel = CH_POT1;
          end
          PH_POT1: begin
            pot1_lvl       = smp;
            scan_phase     = PH_BATT;
            r.next_channel = CH_BATT;
          end
          PH_BATT: begin
            batt_lvl          = smp;
            r.battery_updated = 1'b1;
            scan_phase        = PH_IDLE;
          end
          default: begin
            // Conversion done while idle is ignored.
            scan_phase = PH_IDLE;
          end
        endcase
      end
      FN_READ: begin
        if (idx < PIXELS) r.pixel_data = line_mem[(1 - int'(wr_half)) * PIXELS + idx];
      end
      default: begin
        if (swap_pending) begin
          wr_half           = ~wr_half;
          swap_pending      = 1'b0;
          r.buffers_swapped = 1'b1;
        end
      end
    endcase
    r.swap_deferred = swap_pending;
    r.pot0_level    = pot0_lvl;
    r.pot1_level    = pot1_lvl;
    r.battery_level = batt_lvl;
    return r;
  endfunction

  function automatic string fmt_readout(readout_t r);
    return {$sformatf("chan=%0d si=%0b clk=%0b swp=%0b def=%0b ", r.next_channel,
                      r.si_pulse, r.clock_pulse, r.buffers_swapped, r.swap_deferred),
            $sformatf("pix=%03h p0=%03h p1=%03h bat=%03h upd=%0b", r.pixel_data,
                      r.pot0_level, r.pot1_level, r.battery_level, r.battery_updated)};
  endfunction

  // Names of the fields that differ, empty when the words agree.
  function automatic string diff_fields(readout_t want, readout_t got);
    string s;
    s = "";
    if (got.next_channel    !== want.next_channel)    s = {s, " next_channel"};
    if (got.si_pulse        !== want.si_pulse)        s = {s, " si_pulse"};
    if (got.clock_pulse     !== want.clock_pulse)     s = {s, " clock_pulse"};
    if (got.buffers_swapped !== want.buffers_swapped) s = {s, " buffers_swapped"};
    if (got.swap_deferred   !== want.swap_deferred)   s = {s, " swap_deferred"};
    if (got.pixel_data      !== want.pixel_data)      s = {s, " pixel_data"};
    if (got.pot0_level      !== want.pot0_level)      s = {s, " pot0_level"};
    if (got.pot1_level      !== want.pot1_level)      s = {s, " pot1_level"};
    if (got.battery_level   !== want.battery_level)   s = {s, " battery_level"};
    if (got.battery_updated !== want.battery_updated) s = {s, " battery_updated"};
    return s;
  endfunction

  task automatic log_mismatch(string what, readout_t want, readout_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected %s", fmt_readout(want));
      $display("  actual   %s", fmt_readout(got));
    end
  endtask

  // Sample values lean on the extremes so all-zero and all-one words show up often.
  function automatic logic [AdcW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return AdcW'($urandom);
    endcase
  endfunction

  // Pick a pixel of the read half that has been written; -1 when there is none.
  function automatic int pick_index();
    int base;
    int k;
    base = wr_half ? 0 : PIXELS;
    k    = $urandom_range(0, PIXELS - 1);
    if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 1) ? 0 : PIXELS - 1;
    for (int i = 0; i < PIXELS; i++) begin
      if (line_seen[base + (k + i) % PIXELS]) return (k + i) % PIXELS;
    end
    return -1;
  endfunction

  function automatic void shuffle_idling();
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
  endfunction

  // Offer one word after a random gap, hold it until accepted, then log what it owes.
  task automatic send_word(func_e f, logic [AdcW-1:0] adc, logic busy, logic [IdxW-1:0] idx);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= f;
    in_bus.adc_value   <= adc;
    in_bus.calc_busy   <= busy;
    in_bus.pixel_index <= idx;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    readout_q.push_back(predict_word(f, adc, busy, idx));
  endtask

  // Read a written pixel of the read half; fall back to an apply word before any is written.
  task automatic send_read();
    int idx;
    idx = pick_index();
    if (idx < 0) send_word(FN_APPLY, rand_sample(), 1'($urandom), IdxW'($urandom));
    else         send_word(FN_READ, rand_sample(), 1'($urandom), IdxW'(idx));
  endtask

  task automatic send_noise();
    func_e f;
    f = func_e'($urandom_range(0, 3));
    if (f == FN_READ) send_read();
    else              send_word(f, rand_sample(), 1'($urandom), IdxW'($urandom));
  endtask

  // One full capture: start, a whole line, the trailing clock, pots and battery.
  // Reads, and apply words when mix_apply is set, are mixed in at random.
  task automatic run_capture(bit busy_at_end, bit mix_apply);
    int unsigned n;
    int unsigned r;
    logic        busy;
    send_word(FN_START, rand_sample(), 1'($urandom), IdxW'($urandom));
    n = 0;
    while (scan_phase != PH_IDLE) begin
      if (n % 32 == 0) shuffle_idling();
      n++;
      r = $urandom_range(0, 199);
      if (r < 18) begin
        send_read();
      end else if (r < 22 && mix_apply) begin
        send_word(FN_APPLY, rand_sample(), 1'($urandom), IdxW'($urandom));
      end else begin
        busy = (scan_phase == PH_SCAN && px_cnt == PIXELS) ? busy_at_end : 1'($urandom);
        send_word(FN_DONE, rand_sample(), busy, IdxW'($urandom));
      end
    end
  endtask

  // Conversion done while idle, apply with nothing pending, read falling back to apply.
  task automatic test_idle_words();
    send_word(FN_DONE, '1, 1'b1, '1);
    send_word(FN_DONE, '0, 1'b0, '0);
    send_word(FN_APPLY, 12'h5A5, 1'b0, 7'h2A);
    send_read();
  endtask

  // Start in scan restarts from pixel 0; extreme samples land in the write half.
  task automatic test_restart();
    send_word(FN_START, '0, 1'b0, '0);
    send_word(FN_DONE, '0, 1'b0, 7'h55);
    send_word(FN_DONE, '1, 1'b1, 7'h2A);
    send_word(FN_DONE, 12'hAAA, 1'b0, '1);
    send_word(FN_DONE, 12'h555, 1'b1, '0);
    send_word(FN_DONE, 12'h001, 1'b0, 7'h40);
    send_word(FN_START, '1, 1'b1, '1);
    send_word(FN_DONE, 12'h800, 1'b0, 7'h01);
    send_word(FN_DONE, 12'h7FF, 1'b1, 7'h3F);
    send_word(FN_START, 12'h123, 1'b0, 7'h11);
  endtask

  // Direct swap, deferred swap, direct swap with one pending, then apply twice.
  task automatic test_swap_paths();
    run_capture(1'b0, 1'b1);
    run_capture(1'b1, 1'b0);
    run_capture(1'b0, 1'b0);
    send_word(FN_APPLY, rand_sample(), 1'b1, IdxW'($urandom));
    send_word(FN_APPLY, rand_sample(), 1'b0, IdxW'($urandom));
  endtask

  // Sink holds off for a long stretch while words keep coming; the block must stall.
  task automatic test_backpressure();
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 4) == 0) send_word(FN_APPLY, rand_sample(), 1'($urandom), '0);
      else                           send_read();
    end
  endtask

  // Noise words of any function in any phase, in busy and quiet stretches.
  task automatic test_random_traffic();
    repeat (4) begin
      shuffle_idling();
      repeat (15) send_noise();
    end
  endtask

  // Sink: ready drops for a random stall before each word, or for the long hold-off.
  initial begin : sink_side
    int unsigned stall;
    out_bus.ready = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = snk_idle ? $urandom_range(0, 14) : 0;
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
    end
  end

  // Compare every accepted result word against the oldest one owed.
  always @(posedge clk_i) begin : check_results
    readout_t want;
    readout_t got;
    string    bad;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.next_channel    = chan_e'(out_bus.next_channel);
      got.si_pulse        = out_bus.si_pulse;
      got.clock_pulse     = out_bus.clock_pulse;
      got.buffers_swapped = out_bus.buffers_swapped;
      got.swap_deferred   = out_bus.swap_deferred;
      got.pixel_data      = out_bus.pixel_data;
      got.pot0_level      = out_bus.pot0_level;
      got.pot1_level      = out_bus.pot1_level;
      got.battery_level   = out_bus.battery_level;
      got.battery_updated = out_bus.battery_updated;
      if (readout_q.size() == 0) begin
        log_mismatch("result word with none outstanding", '0, got);
      end else begin
        want = readout_q.pop_front();
        bad  = diff_fields(want, got);
        if (bad != "") log_mismatch({"field mismatch:", bad}, want, got);
      end
    end
  end

  // Watchdog: end the run if it goes far past any legal length.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    // Drive every input to a known value and hold reset.
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = FN_START;
    in_bus.adc_value   = '0;
    in_bus.calc_busy   = 1'b0;
    in_bus.pixel_index = '0;
    src_idle           = 1'b1;
    snk_idle           = 1'b1;
    hold_req           = 1'b0;
    mismatch_cnt       = 0;

    // Tracked state matches the block's reset; the store starts unwritten.
    scan_phase   = PH_IDLE;
    px_cnt       = 0;
    wr_half      = 1'b0;
    swap_pending = 1'b0;
    pot0_lvl     = '0;
    pot1_lvl     = '0;
    batt_lvl     = '0;
    for (int i = 0; i < 2 * PIXELS; i++) begin
      line_mem[i]  = '0;
      line_seen[i] = 1'b0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_words();
    test_restart();
    test_swap_paths();
    test_backpressure();
    test_random_traffic();

    // Stop offering, let every owed word arrive, then watch for strays.
    in_bus.valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
